@@ rtl/scio_pkg.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// scio_pkg - shared types and constants
// Widths, character codes, reply kinds and item/command structs for the
// serial command decoder with software PWM.
// ---------------------------------------------------------------------------
package scio_pkg;

	// command buffer
	localparam int MAX_CMD_LEN = 20;
	localparam int IDX_W       = $clog2(MAX_CMD_LEN);
	localparam int FILL_W      = $clog2(MAX_CMD_LEN + 1);

	// software PWM
	localparam int PWM_PERIOD = 100;
	localparam int CNT_W      = (PWM_PERIOD > 2) ? $clog2(PWM_PERIOD) : 1;
	localparam int DUTY_W     = 16;
	localparam int PIN_W      = 7;
	localparam int PWM_PIN_A  = 3;
	localparam int PWM_PIN_B  = 5;

	// stream packing
	localparam int IN_TDATA_W  = 16;
	localparam int OUT_TDATA_W = 16;
	localparam int VAL_W       = 9;
	localparam int KIND_W      = 2;

	// characters
	localparam logic [7:0] CH_END     = 8'h24; // '$'
	localparam logic [7:0] CH_ZERO    = 8'h30; // '0'
	localparam logic [7:0] CH_ONE     = 8'h31; // '1'
	localparam logic [7:0] CMD_ANALOG = 8'h61; // 'a'
	localparam logic [7:0] CMD_INPUT  = 8'h69; // 'i'
	localparam logic [7:0] CMD_OUTPUT = 8'h6F; // 'o'
	localparam logic [7:0] CMD_LEVEL  = 8'h6C; // 'l'

	// decimal weights of the duty digits
	localparam logic signed [DUTY_W-1:0] DEC_HUNDRED = 16'sd100;
	localparam logic signed [DUTY_W-1:0] DEC_TEN     = 16'sd10;

	// reply kinds
	localparam logic [KIND_W-1:0] KIND_NONE    = 2'd0;
	localparam logic [KIND_W-1:0] KIND_ANALOG  = 2'd1;
	localparam logic [KIND_W-1:0] KIND_INPUT   = 2'd2;
	localparam logic [KIND_W-1:0] KIND_DISCARD = 2'd3;

	typedef struct packed {
		logic       op;         // 1 = timer tick
		logic [7:0] rx_byte;
		logic [2:0] digital_in;
	} item_t;

	typedef struct packed {
		logic [KIND_W-1:0]        kind;
		logic signed [VAL_W-1:0]  value;
		logic                     latch_we;
		logic [2:0]               latch_bit;
		logic                     latch_val;
		logic                     duty_a_we;
		logic                     duty_b_we;
		logic signed [DUTY_W-1:0] level;
	} cmd_t;

	// character as digit: byte minus '0', fits signed 9 bits
	function automatic logic signed [VAL_W-1:0] digit(input logic [7:0] ch);
		digit = $signed({1'b0, ch}) - $signed({1'b0, CH_ZERO});
	endfunction

	function automatic logic signed [DUTY_W-1:0] widen(input logic signed [VAL_W-1:0] d);
		widen = $signed({{(DUTY_W - VAL_W){d[VAL_W-1]}}, d});
	endfunction

endpackage

@@ rtl/scio_cmd.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// scio_cmd - command buffer and decoder
// Stores received bytes at the fill position and decodes the command on '$'.
// ---------------------------------------------------------------------------
module scio_cmd (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           advance,
	input  scio_pkg::item_t item,
	output scio_pkg::cmd_t  cmd
);

	logic [7:0]                  cbuf_q [scio_pkg::MAX_CMD_LEN];
	logic [scio_pkg::FILL_W-1:0] fill_q;
	logic [scio_pkg::FILL_W-1:0] fill_inc;
	logic [scio_pkg::FILL_W-1:0] fill_d;
	logic [scio_pkg::IDX_W-1:0]  fill_idx;
	logic                        fill_wrap;
	logic                        is_end;
	logic [7:0]                  eff [5];
	logic signed [scio_pkg::VAL_W-1:0] n;

	assign fill_idx  = fill_q[scio_pkg::IDX_W-1:0];
	assign fill_inc  = fill_q + 1'b1;
	assign fill_wrap = (fill_inc == scio_pkg::FILL_W'(scio_pkg::MAX_CMD_LEN));
	assign is_end    = (item.rx_byte == scio_pkg::CH_END);
	assign fill_d    = (is_end || fill_wrap) ? '0 : fill_inc;

	// decode sees the buffer with this byte already written
	always_comb begin
		for (int k = 0; k < 5; k++) begin
			eff[k] = (fill_idx == scio_pkg::IDX_W'(k)) ? item.rx_byte : cbuf_q[k];
		end
	end

	assign n = scio_pkg::digit(eff[1]);

	always_comb begin
		cmd           = '0;
		cmd.kind      = scio_pkg::KIND_NONE;
		cmd.latch_bit = n[2:0];
		cmd.latch_val = (eff[2] == scio_pkg::CH_ONE);
		cmd.level     = scio_pkg::widen(scio_pkg::digit(eff[2])) * scio_pkg::DEC_HUNDRED
		              + scio_pkg::widen(scio_pkg::digit(eff[3])) * scio_pkg::DEC_TEN
		              + scio_pkg::widen(scio_pkg::digit(eff[4]));
		if (!item.op) begin
			if (is_end) begin
				unique case (eff[0])
					scio_pkg::CMD_ANALOG: begin
						cmd.kind  = scio_pkg::KIND_ANALOG;
						cmd.value = n;
					end
					scio_pkg::CMD_INPUT: begin
						cmd.kind = scio_pkg::KIND_INPUT;
						if (n >= 9'sd0 && n <= 9'sd2) begin
							case (n[1:0])
								2'd0:    cmd.value = {8'd0, item.digital_in[0]};
								2'd1:    cmd.value = {8'd0, item.digital_in[1]};
								default: cmd.value = {8'd0, item.digital_in[2]};
							endcase
						end
					end
					scio_pkg::CMD_OUTPUT: begin
						cmd.latch_we = (n >= 9'sd0 && n <= 9'sd6);
					end
					scio_pkg::CMD_LEVEL: begin
						cmd.duty_a_we = (n == 9'sd3);
						cmd.duty_b_we = (n == 9'sd5);
					end
					default: ;
				endcase
			end else if (fill_wrap) begin
				cmd.kind = scio_pkg::KIND_DISCARD;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			for (int k = 0; k < scio_pkg::MAX_CMD_LEN; k++) begin
				cbuf_q[k] <= '0;
			end
		end else if (advance && !item.op) begin
			fill_q           <= fill_d;
			cbuf_q[fill_idx] <= item.rx_byte;
		end
	end

endmodule

@@ rtl/scio_pwm.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// scio_pwm - output latches and software PWM
// Holds the seven latches, the PWM counter and the two duty values.
// ---------------------------------------------------------------------------
module scio_pwm (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         advance,
	input  logic                         tick,
	input  scio_pkg::cmd_t               cmd,
	output logic [scio_pkg::PIN_W-1:0]   latch_next
);

	logic [scio_pkg::CNT_W-1:0]         count_q;
	logic [scio_pkg::CNT_W:0]           cnt_inc;
	logic [scio_pkg::CNT_W-1:0]         cnt_next;
	logic                               wrap;
	logic signed [scio_pkg::DUTY_W-1:0] cnt_s;
	logic signed [scio_pkg::DUTY_W-1:0] duty_a_q;
	logic signed [scio_pkg::DUTY_W-1:0] duty_b_q;
	logic [scio_pkg::PIN_W-1:0]         latch_q;

	assign cnt_inc  = {1'b0, count_q} + 1'b1;
	assign wrap     = (cnt_inc >= (scio_pkg::CNT_W + 1)'(scio_pkg::PWM_PERIOD));
	assign cnt_next = wrap ? '0 : cnt_inc[scio_pkg::CNT_W-1:0];
	assign cnt_s    = $signed({{(scio_pkg::DUTY_W - scio_pkg::CNT_W){1'b0}}, cnt_next});

	always_comb begin
		latch_next = latch_q;
		if (tick) begin
			if (wrap) begin
				latch_next[scio_pkg::PWM_PIN_A] = 1'b1;
				latch_next[scio_pkg::PWM_PIN_B] = 1'b1;
			end
			if (duty_a_q <= cnt_s) latch_next[scio_pkg::PWM_PIN_A] = 1'b0;
			if (duty_b_q <= cnt_s) latch_next[scio_pkg::PWM_PIN_B] = 1'b0;
		end else if (cmd.latch_we) begin
			latch_next[cmd.latch_bit] = cmd.latch_val;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			duty_a_q <= '0;
			duty_b_q <= '0;
			latch_q  <= '0;
		end else if (advance) begin
			latch_q <= latch_next;
			if (tick) count_q <= cnt_next;
			if (!tick && cmd.duty_a_we) duty_a_q <= cmd.level;
			if (!tick && cmd.duty_b_we) duty_b_q <= cmd.level;
		end
	end

endmodule

@@ rtl/serial_command_io_with_pwm.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// serial_command_io_with_pwm - serial command decoder with software PWM
// Takes received bytes and timer ticks; drives seven output latches and
// returns analog-read requests, digital input values and discard notices.
// ---------------------------------------------------------------------------
//
//  channel  dir  tdata                                 tuser
//  s_axis   in   [7:0] rx_byte, [10:8] digital_in      [0] op (1 = tick)
//  m_axis   out  [6:0] output_pins, [15:7] reply_value [1:0] reply_kind
//
// One result item per input item, one item per cycle while m_axis_tready holds.
// An item passes the input register, then decode/PWM logic into the
// result register; all state updates as an item leaves the input register.
// Reset clears decoder and PWM state, the 20-byte command buffer included.
// A stalled result holds the result register; the input register still
// takes one more item, then tready drops until the result moves on.
//
module serial_command_io_with_pwm (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_axis_tvalid,
	output logic                               s_axis_tready,
	input  logic [scio_pkg::IN_TDATA_W-1:0]    s_axis_tdata,  // rx_byte, digital_in
	input  logic [0:0]                         s_axis_tuser,  // op
	output logic                               m_axis_tvalid,
	input  logic                               m_axis_tready,
	output logic [scio_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,  // output_pins, reply_value
	output logic [scio_pkg::KIND_W-1:0]        m_axis_tuser   // reply_kind
);

	scio_pkg::item_t item_s1;
	logic            valid_s1;
	logic            out_free;
	logic            advance;
	logic            in_accept;
	scio_pkg::cmd_t  cmd;
	logic [scio_pkg::PIN_W-1:0]         latch_next;

	logic                               valid_s2;
	logic [scio_pkg::PIN_W-1:0]         pins_s2;
	logic [scio_pkg::KIND_W-1:0]        kind_s2;
	logic signed [scio_pkg::VAL_W-1:0]  value_s2;

	// handshake: result register frees the input register
	assign out_free      = !valid_s2 || m_axis_tready;
	assign advance       = valid_s1 && out_free;
	assign s_axis_tready = !valid_s1 || out_free;
	assign in_accept     = s_axis_tvalid && s_axis_tready;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			item_s1.op         <= s_axis_tuser[0];
			item_s1.rx_byte    <= s_axis_tdata[7:0];
			item_s1.digital_in <= s_axis_tdata[10:8];
		end
	end

	scio_cmd u_cmd (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.item    (item_s1),
		.cmd     (cmd)
	);

	scio_pwm u_pwm (
		.clk        (clk),
		.arst_n     (arst_n),
		.advance    (advance),
		.tick       (item_s1.op),
		.cmd        (cmd),
		.latch_next (latch_next)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (m_axis_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			pins_s2  <= latch_next;
			kind_s2  <= cmd.kind;
			value_s2 <= cmd.value;
		end
	end

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata  = {value_s2, pins_s2};
	assign m_axis_tuser  = kind_s2;

`ifndef SYNTHESIS
	// an accepted item is held in the input register next cycle
	a_accept_loads: assert property (@(posedge clk) disable iff (!arst_n)
		in_accept |=> valid_s1)
		else $error("accepted item not held in input register");

	// an item waiting on a full result register keeps its payload
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !out_free |=> valid_s1 && $stable(item_s1))
		else $error("input register lost its item while stalled");

	// no reply value with kinds none and discard
	a_value_zero: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && (kind_s2 == scio_pkg::KIND_NONE || kind_s2 == scio_pkg::KIND_DISCARD)
		|-> value_s2 == '0)
		else $error("nonzero reply value without a reply");

	// a moving item always produces a result next cycle
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> valid_s2)
		else $error("result missing after item left input register");
`endif

endmodule

@@ sim/tb_serial_command_io_with_pwm.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_serial_command_io_with_pwm - self-checking bench for the command decoder
// Drives received bytes and PWM ticks into the slave stream and checks every
// result item on the master stream against an in-bench copy of the decoder,
// the latches, the PWM counter and both duties. The bench starts with a short
// table of hand-picked items and follows it with randomized command traffic,
// with random backpressure on both sides.
// ---------------------------------------------------------------------------
module tb_serial_command_io_with_pwm;

	localparam int RUN_ITEMS = 1330;	// table plus about 1300 random items

	// one result item as it leaves the block
	typedef struct packed {
		logic [scio_pkg::PIN_W-1:0]        pins;
		logic [scio_pkg::KIND_W-1:0]       kind;
		logic signed [scio_pkg::VAL_W-1:0] value;
	} reply_t;

	// one row of the directed table; want is used only when typed is set
	typedef struct packed {
		logic       op;
		logic [7:0] chr;
		logic [2:0] din;
		logic       typed;
		reply_t     want;
	} stim_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic                             s_axis_tvalid = 1'b0;
	logic                             s_axis_tready;
	logic [scio_pkg::IN_TDATA_W-1:0]  s_axis_tdata = '0;	// [7:0] rx_byte, [10:8] digital_in
	logic [0:0]                       s_axis_tuser = '0;	// [0] op
	logic                             m_axis_tvalid;
	logic                             m_axis_tready = 1'b0;
	logic [scio_pkg::OUT_TDATA_W-1:0] m_axis_tdata;	// [6:0] output_pins, [15:7] reply_value
	logic [scio_pkg::KIND_W-1:0]      m_axis_tuser;	// [1:0] reply_kind

	serial_command_io_with_pwm dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	always #1 clk = ~clk;

	// hard stop in case a handshake never completes
	initial begin
		#200_000;
		$display("FAIL serial_command_io_with_pwm");
		$finish;
	end

	// -----------------------------------------------------------------------
	// Decoder shadow: buffer, fill position, latches, PWM counter, duties
	// -----------------------------------------------------------------------
	logic [7:0]                 cmd_buf [scio_pkg::MAX_CMD_LEN];
	int                         fill_pos;
	logic [scio_pkg::PIN_W-1:0] latch_q;
	int                         pwm_pos;
	int                         duty_a;	// channel 3
	int                         duty_b;	// channel 5

	reply_t    reply_q [$];	// results still owed by the block, oldest first
	stim_row_t stim_rows [$];

	int items_in;
	int tick_cnt;
	int err_count;
	int kind_cnt [4];
	int send_gap_pct = 24;
	int recv_stall_pct = 24;

	function automatic void clear_shadow();
		for (int i = 0; i < scio_pkg::MAX_CMD_LEN; i++)
			cmd_buf[i] = 8'h00;
		fill_pos = 0;
		latch_q = '0;
		pwm_pos = 0;
		duty_a = 0;
		duty_b = 0;
	endfunction

	// out-of-range latch numbers are silently ignored
	function automatic void set_latch(int bitn, bit on);
		if (bitn < 0 || bitn > scio_pkg::PIN_W - 1)
			return;
		latch_q[bitn] = on;
	endfunction

	function automatic int char_val(int pos);
		return int'(cmd_buf[pos]) - int'(scio_pkg::CH_ZERO);
	endfunction

	// advance the shadow by one accepted item and return the result it owes
	function automatic reply_t step_decoder(logic op, logic [7:0] chr, logic [2:0] din);
		reply_t r;
		int     n;
		int     lvl;
		r.kind = scio_pkg::KIND_NONE;
		r.value = '0;
		if (op) begin
			pwm_pos++;
			if (pwm_pos >= scio_pkg::PWM_PERIOD) begin
				pwm_pos = 0;
				set_latch(scio_pkg::PWM_PIN_A, 1'b1);
				set_latch(scio_pkg::PWM_PIN_B, 1'b1);
			end
			// signed compare: a negative duty clears on every tick
			if (duty_a <= pwm_pos)
				set_latch(scio_pkg::PWM_PIN_A, 1'b0);
			if (duty_b <= pwm_pos)
				set_latch(scio_pkg::PWM_PIN_B, 1'b0);
		end else begin
			if (fill_pos >= scio_pkg::MAX_CMD_LEN)
				fill_pos = 0;
			cmd_buf[fill_pos] = chr;
			if (chr == scio_pkg::CH_END) begin
				// decode from the buffer as it stands, stale bytes included
				fill_pos = 0;
				n = char_val(1);
				case (cmd_buf[0])
					scio_pkg::CMD_ANALOG: begin
						r.kind = scio_pkg::KIND_ANALOG;
						r.value = n[scio_pkg::VAL_W-1:0];
					end
					scio_pkg::CMD_INPUT: begin
						r.kind = scio_pkg::KIND_INPUT;
						if (n >= 0 && n <= 2)
							r.value = din[n] ? 9'sd1 : 9'sd0;
					end
					scio_pkg::CMD_OUTPUT: set_latch(n, char_val(2) == 1);
					scio_pkg::CMD_LEVEL: begin
						lvl = char_val(2) * 100 + char_val(3) * 10 + char_val(4);
						if (n == scio_pkg::PWM_PIN_A)
							duty_a = lvl;
						if (n == scio_pkg::PWM_PIN_B)
							duty_b = lvl;
					end
					default: ;
				endcase
			end else begin
				fill_pos++;
				if (fill_pos >= scio_pkg::MAX_CMD_LEN) begin
					fill_pos = 0;
					r.kind = scio_pkg::KIND_DISCARD;
				end
			end
		end
		r.pins = latch_q;
		return r;
	endfunction

	// -----------------------------------------------------------------------
	// Sender side
	// -----------------------------------------------------------------------
	// Presents one item, holds it until accepted, then books the result.
	// Returns at the accepting edge with nothing scheduled for that step.
	task automatic push_item(input logic op, input logic [7:0] chr, input logic [2:0] din,
	                         input logic typed, input reply_t want);
		reply_t exp_r;
		while ($urandom_range(0, 99) < send_gap_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {{(scio_pkg::IN_TDATA_W - 11){1'b0}}, din, chr};
		s_axis_tuser <= op;
		do @(posedge clk); while (!s_axis_tready);
		exp_r = step_decoder(op, chr, din);
		reply_q.push_back(typed ? want : exp_r);
		items_in++;
		if (op)
			tick_cnt++;
	endtask

	task automatic push_byte(input logic [7:0] chr);
		push_item(1'b0, chr, 3'($urandom_range(0, 7)), 1'b0, '0);
	endtask

	task automatic push_tick();
		push_item(1'b1, 8'($urandom_range(0, 255)), 3'($urandom_range(0, 7)), 1'b0, '0);
	endtask

	// drop valid and hold off until the block owes nothing
	task automatic wait_for_replies();
		s_axis_tvalid <= 1'b0;
		do @(posedge clk); while (reply_q.size() != 0);
	endtask

	function automatic logic [7:0] any_but_end();
		logic [7:0] c;
		do c = 8'($urandom_range(0, 255)); while (c == scio_pkg::CH_END);
		return c;
	endfunction

	// mostly a decimal digit in lo..hi, now and then any other byte
	function automatic logic [7:0] digit_char(int lo, int hi);
		logic [7:0] d;
		if ($urandom_range(0, 99) < 8)
			return any_but_end();
		d = 8'($urandom_range(lo, hi));
		return scio_pkg::CH_ZERO + d;
	endfunction

	function automatic void add_row(logic op, logic [7:0] chr, logic [2:0] din, logic typed,
	                                logic [scio_pkg::PIN_W-1:0] pins,
	                                logic [scio_pkg::KIND_W-1:0] kind,
	                                logic signed [scio_pkg::VAL_W-1:0] value);
		stim_row_t r;
		r.op = op;
		r.chr = chr;
		r.din = din;
		r.typed = typed;
		r.want.pins = pins;
		r.want.kind = kind;
		r.want.value = value;
		stim_rows.push_back(r);
	endfunction

	// -----------------------------------------------------------------------
	// Receiver side: random stalls, in-order check of every result item
	// -----------------------------------------------------------------------
	always @(posedge clk)
		m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);

	task automatic flag_mismatch(input string what);
		err_count++;
		$display("%0t ns: mismatch: %s", $time, what);
	endtask

	always @(posedge clk) begin
		reply_t got;
		reply_t exp_r;
		if (m_axis_tvalid && m_axis_tready) begin
			got.pins = m_axis_tdata[scio_pkg::PIN_W-1:0];
			got.value = m_axis_tdata[scio_pkg::PIN_W+scio_pkg::VAL_W-1:scio_pkg::PIN_W];
			got.kind = m_axis_tuser;
			kind_cnt[got.kind]++;
			if (reply_q.size() == 0) begin
				flag_mismatch("result item with nothing outstanding");
			end else begin
				exp_r = reply_q.pop_front();
				if (got.pins !== exp_r.pins)
					flag_mismatch($sformatf("output_pins %h, expected %h",
						got.pins, exp_r.pins));
				if (got.kind !== exp_r.kind)
					flag_mismatch($sformatf("reply_kind %0d, expected %0d",
						got.kind, exp_r.kind));
				if (got.value !== exp_r.value)
					flag_mismatch($sformatf("reply_value %0d, expected %0d",
						got.value, exp_r.value));
			end
		end
	end

	// -----------------------------------------------------------------------
	// Main sequence
	// -----------------------------------------------------------------------
	initial begin
		int pick;
		bit mid_drained;
		mid_drained = 0;
		clear_shadow();

		// Directed table. Typed rows carry their result; the rest use the shadow.
		// first tick after reset: duty 0 keeps both PWM latches low
		add_row(1'b1, 8'hFF, 3'h7, 1'b1, 7'h00, scio_pkg::KIND_NONE, 9'sd0);
		// analog read, top and bottom of the byte range
		add_row(1'b0, scio_pkg::CMD_ANALOG, 3'h0, 1'b0, '0, '0, '0);
		add_row(1'b0, 8'hFF, 3'h0, 1'b0, '0, '0, '0);
		add_row(1'b0, scio_pkg::CH_END, 3'h7, 1'b1, 7'h00, scio_pkg::KIND_ANALOG, 9'sd207);
		add_row(1'b0, scio_pkg::CMD_ANALOG, 3'h0, 1'b0, '0, '0, '0);
		add_row(1'b0, 8'h00, 3'h0, 1'b0, '0, '0, '0);
		add_row(1'b0, scio_pkg::CH_END, 3'h0, 1'b1, 7'h00, scio_pkg::KIND_ANALOG, -9'sd48);
		// input read, highest valid pin, then an unknown pin
		add_row(1'b0, scio_pkg::CMD_INPUT, 3'h0, 1'b0, '0, '0, '0);
		add_row(1'b0, scio_pkg::CH_ZERO + 8'd2, 3'h0, 1'b0, '0, '0, '0);
		add_row(1'b0, scio_pkg::CH_END, 3'b100, 1'b1, 7'h00, scio_pkg::KIND_INPUT, 9'sd1);
		add_row(1'b0, scio_pkg::CMD_INPUT, 3'h0, 1'b0, '0, '0, '0);
		add_row(1'b0, scio_pkg::CH_ZERO + 8'd7, 3'h0, 1'b0, '0, '0, '0);
		add_row(1'b0, scio_pkg::CH_END, 3'h7, 1'b1, 7'h00, scio_pkg::KIND_INPUT, 9'sd0);
		// set the top latch, then an out-of-range latch number
		add_row(1'b0, scio_pkg::CMD_OUTPUT, 3'h0, 1'b0, '0, '0, '0);
		add_row(1'b0, scio_pkg::CH_ZERO + 8'd6, 3'h0, 1'b0, '0, '0, '0);
		add_row(1'b0, scio_pkg::CH_ONE, 3'h0, 1'b0, '0, '0, '0);
		add_row(1'b0, scio_pkg::CH_END, 3'h0, 1'b1, 7'h40, scio_pkg::KIND_NONE, 9'sd0);
		add_row(1'b0, scio_pkg::CMD_OUTPUT, 3'h0, 1'b0, '0, '0, '0);
		add_row(1'b0, scio_pkg::CH_ZERO + 8'd9, 3'h0, 1'b0, '0, '0, '0);
		add_row(1'b0, scio_pkg::CH_END, 3'h0, 1'b1, 7'h40, scio_pkg::KIND_NONE, 9'sd0);
		// duty above the period on channel 5
		add_row(1'b0, scio_pkg::CMD_LEVEL, 3'h0, 1'b0, '0, '0, '0);
		add_row(1'b0, scio_pkg::CH_ZERO + 8'd5, 3'h0, 1'b0, '0, '0, '0);
		add_row(1'b0, scio_pkg::CH_ZERO + 8'd9, 3'h0, 1'b0, '0, '0, '0);
		add_row(1'b0, scio_pkg::CH_ZERO + 8'd9, 3'h0, 1'b0, '0, '0, '0);
		add_row(1'b0, scio_pkg::CH_ZERO + 8'd9, 3'h0, 1'b0, '0, '0, '0);
		add_row(1'b0, scio_pkg::CH_END, 3'h0, 1'b0, '0, '0, '0);
		// unknown channel, decoded over stale buffer bytes
		add_row(1'b0, scio_pkg::CMD_LEVEL, 3'h0, 1'b0, '0, '0, '0);
		add_row(1'b0, scio_pkg::CH_ZERO + 8'd7, 3'h0, 1'b0, '0, '0, '0);
		add_row(1'b0, scio_pkg::CH_END, 3'h0, 1'b0, '0, '0, '0);
		// bare terminator: unknown letter, nothing happens
		add_row(1'b0, scio_pkg::CH_END, 3'h5, 1'b1, 7'h40, scio_pkg::KIND_NONE, 9'sd0);
		add_row(1'b1, 8'h00, 3'h0, 1'b0, '0, '0, '0);

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (stim_rows[i])
			push_item(stim_rows[i].op, stim_rows[i].chr, stim_rows[i].din,
			          stim_rows[i].typed, stim_rows[i].want);
		wait_for_replies();

		// Random traffic: mostly well-formed commands and tick bursts, with
		// stale/short commands, overlong runs and raw noise mixed in.
		while (items_in < RUN_ITEMS) begin
			// a stretch with no gaps or stalls on either side
			if (items_in >= 500 && items_in < 700) begin
				send_gap_pct = 0;
				recv_stall_pct = 0;
			end else begin
				send_gap_pct = 24;
				recv_stall_pct = 24;
			end
			if (!mid_drained && items_in >= 900) begin
				wait_for_replies();
				mid_drained = 1;
			end
			pick = $urandom_range(0, 99);
			if (pick < 35) begin
				repeat ($urandom_range(1, 8))
					push_tick();
			end else if (pick < 80) begin
				case ($urandom_range(0, 3))
					0: begin
						push_byte(scio_pkg::CMD_ANALOG);
						push_byte(8'($urandom_range(0, 255)));
					end
					1: begin
						push_byte(scio_pkg::CMD_INPUT);
						push_byte(digit_char(0, 3));
					end
					2: begin
						push_byte(scio_pkg::CMD_OUTPUT);
						push_byte(digit_char(0, 7));
						push_byte(digit_char(0, 1));
					end
					default: begin
						push_byte(scio_pkg::CMD_LEVEL);
						if ($urandom_range(0, 99) < 80)
							push_byte(scio_pkg::CH_ZERO + (($urandom_range(0, 1) != 0) ?
								8'(scio_pkg::PWM_PIN_A) : 8'(scio_pkg::PWM_PIN_B)));
						else
							push_byte(digit_char(0, 9));
						push_byte(digit_char(0, 1));
						push_byte(digit_char(0, 9));
						push_byte(digit_char(0, 9));
					end
				endcase
				push_byte(scio_pkg::CH_END);
			end else if (pick < 90) begin
				// short command over whatever the buffer still holds
				repeat ($urandom_range(0, 3))
					push_byte(any_but_end());
				push_byte(scio_pkg::CH_END);
			end else if (pick < 95) begin
				repeat ($urandom_range(scio_pkg::MAX_CMD_LEN, 2 * scio_pkg::MAX_CMD_LEN + 5))
					push_byte(any_but_end());
			end else begin
				repeat ($urandom_range(1, 5))
					push_byte(8'($urandom_range(0, 255)));
			end
		end

		wait_for_replies();
		repeat (8) @(posedge clk);

		$display("run: %0d items in, %0d of them PWM ticks", items_in, tick_cnt);
		$display("replies seen: %0d plain, %0d analog, %0d input, %0d discarded",
		         kind_cnt[scio_pkg::KIND_NONE], kind_cnt[scio_pkg::KIND_ANALOG],
		         kind_cnt[scio_pkg::KIND_INPUT], kind_cnt[scio_pkg::KIND_DISCARD]);
		if (err_count == 0)
			$display("PASS serial_command_io_with_pwm");
		else
			$display("FAIL serial_command_io_with_pwm");
		$finish;
	end

endmodule
